// ===== rtl/core/shn_pkg.sv =====
// ----------------------------------------------------------------------------
// shn_pkg: shared types and constants for the height field normal unit
// Payload structs, datapath widths and the neighbor tap table.
// ----------------------------------------------------------------------------
package shn_pkg;

	// grid geometry, GRID_SIZE = 2**GRID_BITS
	localparam int GRID_BITS = 6;
	localparam int ADDR_W    = 2 * GRID_BITS;
	localparam int DEPTH     = 1 << ADDR_W;

	// datapath widths
	localparam int HEIGHT_W = 16;
	localparam int DAMP_W   = 16;
	localparam int SUM_W    = 20;
	localparam int MAG_W    = 19;
	localparam int RAW_W    = MAG_W + DAMP_W;
	localparam int DMAG_W   = 27;
	localparam int PROD_W   = 2 * DMAG_W;
	localparam int L2_W     = PROD_W + 1;
	localparam int LEN_W    = 28;
	localparam int FRAC_W   = 14;
	localparam int REM_W    = DMAG_W + FRAC_W + 1;
	localparam int QUO_W    = FRAC_W + 1;

	localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd26214;

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                       kind;
		logic [GRID_BITS-1:0]       grid_row;
		logic [GRID_BITS-1:0]       grid_col;
		logic signed [HEIGHT_W-1:0] height_sample;
	} item_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic [14:0]        normal_y;
		logic signed [15:0] normal_z;
	} result_t;

	// one neighbor: signed offsets and signed sobel weights
	typedef struct packed {
		logic signed [1:0] dc;
		logic signed [1:0] dr;
		logic signed [2:0] wx;
		logic signed [2:0] wy;
	} tap_t;

	function automatic tap_t tap_of(input logic [2:0] k);
		tap_t t;
		case (k)
			3'd0:    t = '{dc: -2'sd1, dr: -2'sd1, wx: -3'sd1, wy: -3'sd1};
			3'd1:    t = '{dc:  2'sd0, dr: -2'sd1, wx:  3'sd0, wy: -3'sd2};
			3'd2:    t = '{dc:  2'sd1, dr: -2'sd1, wx:  3'sd1, wy: -3'sd1};
			3'd3:    t = '{dc: -2'sd1, dr:  2'sd0, wx: -3'sd2, wy:  3'sd0};
			3'd4:    t = '{dc:  2'sd1, dr:  2'sd0, wx:  3'sd2, wy:  3'sd0};
			3'd5:    t = '{dc: -2'sd1, dr:  2'sd1, wx: -3'sd1, wy:  3'sd1};
			3'd6:    t = '{dc:  2'sd0, dr:  2'sd1, wx:  3'sd0, wy:  3'sd2};
			default: t = '{dc:  2'sd1, dr:  2'sd1, wx:  3'sd1, wy:  3'sd1};
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/sobel_heightfield_normals_top.sv =====
// ----------------------------------------------------------------------------
// sobel_heightfield_normals_top: unit normals from a stored height field
// Stores height samples, and for a query forms weighted sobel gradients and
// normalizes (-dx, 1, dy) with a bit-serial square root and divider.
// ----------------------------------------------------------------------------
// a write is taken while idle and busy stays low; it returns nothing
// a query reads the eight neighbors through the one memory port, drains the
// read, runs the multiply steps, the square root steps and three divides, then
// registers its result in the output register; one query at a time
// the next item is taken in the cycle of the strobe; reset clears control and
// loads the damping default; the height memory holds no reset; the strobe lasts one cycle
module sobel_heightfield_normals_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  shn_pkg::item_t                 item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [shn_pkg::DAMP_W-1:0]     cfg_data,
	output logic                           result_valid,
	output shn_pkg::result_t               result
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_READ = 4'd1;
	localparam logic [3:0] ST_LAST = 4'd2;
	localparam logic [3:0] ST_MDX  = 4'd3;
	localparam logic [3:0] ST_MDY  = 4'd4;
	localparam logic [3:0] ST_SQX  = 4'd5;
	localparam logic [3:0] ST_SQY  = 4'd6;
	localparam logic [3:0] ST_SUM  = 4'd7;
	localparam logic [3:0] ST_SQRT = 4'd8;
	localparam logic [3:0] ST_DSET = 4'd9;
	localparam logic [3:0] ST_DIV  = 4'd10;

	logic [3:0]                      state_q;
	logic [shn_pkg::DAMP_W-1:0]      damping_q;
	logic [shn_pkg::GRID_BITS-1:0]   row_q, col_q;
	logic [2:0]                      tap_q;
	logic signed [shn_pkg::SUM_W-1:0] sx_q, sy_q;
	logic                            rvalid_s1;
	logic signed [2:0]               wx_s1, wy_s1;
	logic signed [shn_pkg::HEIGHT_W-1:0] rdat_s1;
	logic [shn_pkg::HEIGHT_W-1:0]    mem [shn_pkg::DEPTH];
	logic [shn_pkg::PROD_W-1:0]      prod_q;
	logic [shn_pkg::DMAG_W-1:0]      dxm_q, dym_q;
	logic [shn_pkg::L2_W-1:0]        xr_q, rt_q, bt_q;
	logic [shn_pkg::LEN_W-1:0]       len_q;
	logic [shn_pkg::REM_W-1:0]       rem_q, dsr_q;
	logic [shn_pkg::QUO_W-1:0]       quo_q, ny_q, nx_q;
	logic [3:0]                      cnt_q;
	logic [1:0]                      div_q;
	logic                            valid_q;
	shn_pkg::result_t                result_q;

	logic                            accept;
	shn_pkg::tap_t                   tap;
	logic [shn_pkg::GRID_BITS-1:0]   rd_col, rd_row;
	logic [shn_pkg::MAG_W-1:0]       sxm, sym;
	logic [shn_pkg::RAW_W:0]         rnd;
	logic [shn_pkg::DMAG_W-1:0]      dmag_rnd;
	logic [shn_pkg::L2_W-1:0]        rt_try;
	logic                            rt_fit;
	logic [shn_pkg::L2_W-1:0]        rt_next;
	logic                            div_fit;
	logic [shn_pkg::QUO_W-1:0]       quo_next;
	logic [shn_pkg::REM_W-1:0]       half_len;
	logic                            neg_x, neg_z;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign result_valid = valid_q;
	assign result    = result_q;

	// neighbor address, wraps at the field edges
	always_comb begin
		tap    = shn_pkg::tap_of(tap_q);
		rd_col = col_q + shn_pkg::GRID_BITS'(signed'(tap.dc));
		rd_row = row_q + shn_pkg::GRID_BITS'(signed'(tap.dr));
	end

	// height memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept && item.kind == shn_pkg::KIND_WRITE) begin
			mem[{item.grid_row, item.grid_col}] <= item.height_sample;
		end
		rdat_s1 <= mem[{rd_row, rd_col}];
		wx_s1   <= tap.wx;
		wy_s1   <= tap.wy;
	end

	// magnitudes and damping round
	always_comb begin
		sxm      = sx_q[shn_pkg::SUM_W-1] ? shn_pkg::MAG_W'(-sx_q) : shn_pkg::MAG_W'(sx_q);
		sym      = sy_q[shn_pkg::SUM_W-1] ? shn_pkg::MAG_W'(-sy_q) : shn_pkg::MAG_W'(sy_q);
		rnd      = {1'b0, prod_q[shn_pkg::RAW_W-1:0]} + (shn_pkg::RAW_W+1)'(128);
		dmag_rnd = rnd[shn_pkg::DMAG_W+7:8];
		neg_x    = !sx_q[shn_pkg::SUM_W-1] && (sx_q != '0);
		neg_z    = sy_q[shn_pkg::SUM_W-1];
	end

	// square root step, one result bit per cycle
	always_comb begin
		rt_try = rt_q + bt_q;
		rt_fit = (xr_q >= rt_try);
		rt_next = rt_fit ? ((rt_q >> 1) + bt_q) : (rt_q >> 1);
	end

	// restoring divide step, one quotient bit per cycle
	always_comb begin
		div_fit  = (rem_q >= dsr_q);
		quo_next = {quo_q[shn_pkg::QUO_W-2:0], div_fit};
		half_len = shn_pkg::REM_W'(len_q >> 1);
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			damping_q <= shn_pkg::DAMPING_RESET;
			rvalid_s1 <= 1'b0;
			valid_q   <= 1'b0;
			tap_q     <= '0;
			cnt_q     <= '0;
			div_q     <= '0;
		end else begin
			valid_q   <= (state_q == ST_DIV) && (cnt_q == '0) && (div_q == 2'd2);
			rvalid_s1 <= (state_q == ST_READ);
			if (cfg_valid && cfg_ready) begin
				damping_q <= cfg_data;
			end
			// sobel accumulate of the neighbor read last cycle
			if (rvalid_s1) begin
				sx_q <= sx_q + (shn_pkg::SUM_W'(rdat_s1) * shn_pkg::SUM_W'(wx_s1));
				sy_q <= sy_q + (shn_pkg::SUM_W'(rdat_s1) * shn_pkg::SUM_W'(wy_s1));
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.kind == shn_pkg::KIND_QUERY) begin
						row_q   <= item.grid_row;
						col_q   <= item.grid_col;
						tap_q   <= '0;
						sx_q    <= '0;
						sy_q    <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					tap_q <= tap_q + 3'd1;
					if (tap_q == 3'd7) state_q <= ST_LAST;
				end
				ST_LAST: state_q <= ST_MDX;
				ST_MDX: begin
					prod_q  <= shn_pkg::PROD_W'(sxm * damping_q);
					state_q <= ST_MDY;
				end
				ST_MDY: begin
					dxm_q   <= dmag_rnd;
					prod_q  <= shn_pkg::PROD_W'(sym * damping_q);
					state_q <= ST_SQX;
				end
				ST_SQX: begin
					dym_q   <= dmag_rnd;
					prod_q  <= dxm_q * dxm_q;
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					xr_q    <= {1'b0, prod_q} + (shn_pkg::L2_W'(1) << 32);
					prod_q  <= dym_q * dym_q;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					xr_q    <= xr_q + {1'b0, prod_q};
					rt_q    <= '0;
					bt_q    <= shn_pkg::L2_W'(1) << (shn_pkg::L2_W - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (rt_fit) xr_q <= xr_q - rt_try;
					rt_q <= rt_next;
					bt_q <= bt_q >> 2;
					if (bt_q[0]) begin
						len_q   <= rt_next[shn_pkg::LEN_W-1:0];
						div_q   <= '0;
						state_q <= ST_DSET;
					end
				end
				ST_DSET: begin
					dsr_q <= shn_pkg::REM_W'(len_q) << shn_pkg::FRAC_W;
					quo_q <= '0;
					cnt_q <= 4'(shn_pkg::QUO_W - 1);
					case (div_q)
						2'd0:    rem_q <= (shn_pkg::REM_W'(1) << 30) + half_len;
						2'd1:    rem_q <= (shn_pkg::REM_W'(dxm_q) << shn_pkg::FRAC_W) + half_len;
						default: rem_q <= (shn_pkg::REM_W'(dym_q) << shn_pkg::FRAC_W) + half_len;
					endcase
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_fit) rem_q <= rem_q - dsr_q;
					dsr_q <= dsr_q >> 1;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == '0) begin
						div_q <= div_q + 2'd1;
						case (div_q)
							2'd0: begin
								ny_q    <= quo_next;
								state_q <= ST_DSET;
							end
							2'd1: begin
								nx_q    <= quo_next;
								state_q <= ST_DSET;
							end
							default: begin
								result_q.normal_y <= ny_q;
								result_q.normal_x <= neg_x ? -$signed({1'b0, nx_q})
								                           : $signed({1'b0, nx_q});
								result_q.normal_z <= neg_z ? -$signed({1'b0, quo_next})
								                           : $signed({1'b0, quo_next});
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/shn_checker.sv =====
// ----------------------------------------------------------------------------
// shn_checker: port level checks for the height field normal unit
// Watches command, strobe and result ports over time.
// ----------------------------------------------------------------------------
module shn_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  shn_pkg::item_t   item,
	input  logic             result_valid,
	input  shn_pkg::result_t result
);

	// a query keeps the unit busy after it is taken
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == shn_pkg::KIND_QUERY |=> busy)
		else $error("query accepted but unit not busy");

	// a write never occupies the unit
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == shn_pkg::KIND_WRITE |=> !busy)
		else $error("write left unit busy");

	// a result beat comes with the unit released
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// strobe lasts one cycle
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// y component is one over a length of at least one
	a_ny_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.normal_y != '0 && result.normal_y <= 15'd16384)
		else $error("normal_y out of range");

endmodule

bind sobel_heightfield_normals_top shn_checker u_shn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);
